[rtl/ovn_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ovn_pkg
// Shared types and fixed constants of the octave value noise block.
// -----------------------------------------------------------------------------
package ovn_pkg;

	// weights are unsigned Q24.24; the largest one stays below 2^48
	localparam int WW          = 48;
	localparam int ACC_W       = WW + 16;
	localparam int DVD_W       = WW + 8;
	localparam int SEED_W      = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPW         = 2;

	localparam logic [WW-1:0]     WEIGHT_ONE = WW'(64'd1 << 24);
	localparam logic [SEED_W-1:0] BIAS_MIN   = 16'd26;

	typedef enum logic {
		KIND_WRITE,
		KIND_QUERY
	} kind_t;

	typedef enum logic {
		REG_OCTAVE_COUNT,
		REG_PERSISTENCE_BIAS
	} reg_idx_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        x;
		logic [7:0]        y;
		logic [SEED_W-1:0] seed;
	} item_t;

	typedef struct packed {
		logic          ready;
		logic [WW-1:0] weight;
	} wgt_t;

	typedef enum logic [1:0] {
		W_IDLE,
		W_LOAD,
		W_RUN
	} wgt_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_READ,
		B_MUL1,
		B_MUL2,
		B_ROUND,
		B_WMUL,
		B_ACC,
		B_NORM,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage
`default_nettype wire

[rtl/ovn_if.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ovn_if
// Request and response channels of the octave value noise block.
// -----------------------------------------------------------------------------
interface ovn_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  coord_x;
	logic [7:0]  coord_y;
	logic [15:0] seed_value;

	modport source (output valid, req_type, coord_x, coord_y, seed_value, input ready);
	modport sink   (input valid, req_type, coord_x, coord_y, seed_value, output ready);
endinterface

interface ovn_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

[rtl/ovn_front.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ovn_front
// Accept request words, tag them as seed write or query, queue them in order.
// -----------------------------------------------------------------------------
module ovn_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ovn_req_if.sink            req,
	output ovn_pkg::item_t     q_item,
	output logic               q_valid,
	input  wire logic          q_pop
);
	import ovn_pkg::*;

	item_t            fifo_q [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_q;
	logic [QPW-1:0]   rd_q;
	logic [QPW:0]     cnt_q;
	logic             push;
	logic             pop;

	assign req.ready = (cnt_q != (QPW+1)'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_item    = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].kind <= req.req_type ? KIND_QUERY : KIND_WRITE;
			fifo_q[wr_q].x    <= req.coord_x;
			fifo_q[wr_q].y    <= req.coord_y;
			fifo_q[wr_q].seed <= req.seed_value;
		end
	end

endmodule
`default_nettype wire

[rtl/ovn_weight.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ovn_weight
// Octave weight table: w0 = 1.0, each next weight is floor(w * 256 / bias),
// rebuilt by a bit-serial divider after reset and after each bias write.
// -----------------------------------------------------------------------------
module ovn_weight #(
	parameter  int MAX_OCTAVES = 8,
	localparam int IW          = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          restart,
	input  wire logic [15:0]   bias,
	input  wire logic [IW-1:0] rd_idx,
	output ovn_pkg::wgt_t      wgt
);
	import ovn_pkg::*;

	localparam int BW = $clog2(DVD_W);

	wgt_state_t        st_q;
	wgt_state_t        st_d;
	logic [IW:0]       idx_q;
	logic [BW-1:0]     bit_q;
	logic [16:0]       rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [WW-1:0]     prev_q;
	logic [WW-1:0]     w_q [MAX_OCTAVES];
	logic [16:0]       rem_sh;
	logic              ge;
	logic [16:0]       rem_nx;
	logic [DVD_W-1:0]  quo_nx;
	logic              last_bit;

	assign rem_sh   = {rem_q[15:0], dvd_q[DVD_W-1]};
	assign ge       = (rem_sh >= {1'b0, bias});
	assign rem_nx   = ge ? (rem_sh - {1'b0, bias}) : rem_sh;
	assign quo_nx   = {quo_q[DVD_W-2:0], ge};
	assign last_bit = (bit_q == BW'(DVD_W - 1));

	assign wgt.ready  = (st_q == W_IDLE);
	assign wgt.weight = w_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= W_LOAD;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		if (restart) begin
			st_d = W_LOAD;
		end else begin
			case (st_q)
				W_IDLE: st_d = W_IDLE;
				W_LOAD: st_d = (int'(idx_q) >= MAX_OCTAVES) ? W_IDLE : W_RUN;
				W_RUN:  st_d = last_bit ? W_LOAD : W_RUN;
				default: st_d = W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= (IW+1)'(1);
			prev_q <= WEIGHT_ONE;
			bit_q  <= '0;
		end else if (restart) begin
			idx_q  <= (IW+1)'(1);
			prev_q <= WEIGHT_ONE;
			bit_q  <= '0;
		end else begin
			case (st_q)
				W_LOAD: bit_q <= '0;
				W_RUN: begin
					bit_q <= bit_q + 1'b1;
					if (last_bit) begin
						idx_q  <= idx_q + 1'b1;
						prev_q <= quo_nx[WW-1:0];
					end
				end
				default: bit_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			W_LOAD: begin
				w_q[0] <= WEIGHT_ONE;
				dvd_q  <= {prev_q, 8'h00};
				rem_q  <= '0;
				quo_q  <= '0;
			end
			W_RUN: begin
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (last_bit)
					w_q[idx_q[IW-1:0]] <= quo_nx[WW-1:0];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/ovn_back.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ovn_back
// Seed map and query engine: bilinear octave samples, weighted sum, and a
// radix-2 normalizing divide into a result register.
// -----------------------------------------------------------------------------
module ovn_back #(
	parameter  int SIDE        = 256,
	parameter  int MAX_OCTAVES = 8,
	localparam int IW          = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ovn_pkg::item_t q_item,
	input  wire logic          q_valid,
	output logic               q_pop,
	input  wire logic [3:0]    octave_count,
	input  wire ovn_pkg::wgt_t wgt,
	output logic [IW-1:0]      wgt_idx,
	ovn_rsp_if.source          rsp
);
	import ovn_pkg::*;

	localparam int LS = $clog2(SIDE);
	localparam int PW = LS + 1;
	localparam int AW = 2 * LS;
	localparam int TW = PW + 17;
	localparam int NW = 2 * PW + 18;
	localparam int KW = $clog2(LS + 1);
	localparam int PRW = WW + 16;

	logic [SEED_W-1:0] seed_mem_q [SIDE*SIDE];
	logic [SEED_W-1:0] rd_q;

	back_state_t      st_q;
	back_state_t      st_d;
	logic             mem_we;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    waddr;

	logic [LS-1:0]    x_q;
	logic [LS-1:0]    y_q;
	logic [IW:0]      n_q;
	logic [IW:0]      o_q;
	logic [2:0]       c_q;
	logic [SEED_W-1:0] s_q [4];
	logic [TW-1:0]    top_s1;
	logic [TW-1:0]    bot_s1;
	logic [NW-1:0]    num_s2;
	logic [15:0]      v_s3;
	logic [PRW-1:0]   prod_s4;
	logic [ACC_W-1:0] acc_q;
	logic [WW-1:0]    wsum_q;
	logic [WW-1:0]    rem_q;
	logic [15:0]      dq_q;
	logic [15:0]      quo_q;
	logic [3:0]       dcnt_q;
	logic             out_valid_q;
	logic [15:0]      out_q;

	logic [IW:0]      n_clamp;
	logic [KW-1:0]    k;
	logic [PW-1:0]    p;
	logic [LS-1:0]    pm;
	logic [LS-1:0]    x1;
	logic [LS-1:0]    y1;
	logic [LS-1:0]    x2;
	logic [LS-1:0]    y2;
	logic [LS-1:0]    dx;
	logic [LS-1:0]    dy;
	logic [PW-1:0]    pdx;
	logic [PW-1:0]    pdy;
	logic [NW-1:0]    half;
	logic [NW-1:0]    rounded;
	logic [ACC_W-1:0] nrm;
	logic [WW:0]      rem_sh;
	logic             ge;
	logic             out_free;
	logic             last_oct;

	// octave geometry: pitch 2^k, cell corner and offset inside the cell
	assign k    = KW'(LS) - KW'(o_q);
	assign p    = PW'(1) << k;
	assign pm   = LS'(p - 1'b1);
	assign x1   = x_q & ~pm;
	assign y1   = y_q & ~pm;
	assign dx   = x_q & pm;
	assign dy   = y_q & pm;
	assign x2   = x1 + LS'(p);
	assign y2   = y1 + LS'(p);
	assign pdx  = p - PW'(dx);
	assign pdy  = p - PW'(dy);
	assign half = (k == '0) ? '0 : (NW'(1) << ({k, 1'b0} - 1'b1));
	assign rounded = (num_s2 + half) >> {k, 1'b0};

	assign nrm    = acc_q + ACC_W'(wsum_q >> 1);
	assign rem_sh = {rem_q, dq_q[15]};
	assign ge     = (rem_sh >= {1'b0, wsum_q});

	assign wgt_idx  = o_q[IW-1:0];
	assign out_free = !out_valid_q || rsp.ready;
	assign last_oct = ((o_q + 1'b1) == n_q);
	assign waddr    = {LS'(q_item.y), LS'(q_item.x)};
	assign raddr    = {c_q[1] ? y2 : y1, c_q[0] ? x2 : x1};

	always_comb begin
		if (octave_count == 4'd0)
			n_clamp = (IW+1)'(1);
		else if (int'(octave_count) > MAX_OCTAVES)
			n_clamp = (IW+1)'(MAX_OCTAVES);
		else
			n_clamp = (IW+1)'(octave_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= B_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d   = st_q;
		q_pop  = 1'b0;
		mem_we = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					if (q_item.kind == KIND_WRITE) begin
						q_pop  = 1'b1;
						mem_we = 1'b1;
					end else if (wgt.ready) begin
						q_pop = 1'b1;
						st_d  = B_READ;
					end
				end
			end
			B_READ:  st_d = (c_q == 3'd4) ? B_MUL1 : B_READ;
			B_MUL1:  st_d = B_MUL2;
			B_MUL2:  st_d = B_ROUND;
			B_ROUND: st_d = B_WMUL;
			B_WMUL:  st_d = B_ACC;
			B_ACC:   st_d = last_oct ? B_NORM : B_READ;
			B_NORM:  st_d = B_DIV;
			B_DIV:   st_d = (dcnt_q == 4'd15) ? B_DONE : B_DIV;
			B_DONE:  st_d = out_free ? B_IDLE : B_DONE;
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			seed_mem_q[waddr] <= q_item.seed;
		rd_q <= seed_mem_q[raddr];
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q    <= '0;
			n_q    <= (IW+1)'(1);
			c_q    <= '0;
			dcnt_q <= '0;
		end else begin
			case (st_q)
				B_IDLE: begin
					o_q    <= '0;
					n_q    <= n_clamp;
					c_q    <= '0;
					dcnt_q <= '0;
				end
				B_READ: c_q <= c_q + 1'b1;
				B_ACC: begin
					o_q <= o_q + 1'b1;
					c_q <= '0;
				end
				B_DIV: dcnt_q <= dcnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				x_q    <= LS'(q_item.x);
				y_q    <= LS'(q_item.y);
				acc_q  <= '0;
				wsum_q <= '0;
			end
			B_READ: begin
				if (c_q != 3'd0)
					s_q[c_q[1:0] - 2'd1] <= rd_q;
			end
			B_MUL1: begin
				top_s1 <= TW'(pdx) * TW'(s_q[0]) + TW'(dx) * TW'(s_q[1]);
				bot_s1 <= TW'(pdx) * TW'(s_q[2]) + TW'(dx) * TW'(s_q[3]);
			end
			B_MUL2:  num_s2 <= NW'(pdy) * NW'(top_s1) + NW'(dy) * NW'(bot_s1);
			B_ROUND: v_s3 <= rounded[15:0];
			B_WMUL:  prod_s4 <= PRW'(wgt.weight) * PRW'(v_s3);
			B_ACC: begin
				acc_q  <= acc_q + ACC_W'(prod_s4);
				wsum_q <= wsum_q + wgt.weight;
			end
			B_NORM: begin
				rem_q <= nrm[ACC_W-1:16];
				dq_q  <= nrm[15:0];
				quo_q <= '0;
			end
			B_DIV: begin
				rem_q <= ge ? WW'(rem_sh - {1'b0, wsum_q}) : rem_sh[WW-1:0];
				dq_q  <= {dq_q[14:0], 1'b0};
				quo_q <= {quo_q[14:0], ge};
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (st_q == B_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == B_DONE && out_free)
			out_q <= quo_q;
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.noise_value = out_q;

	a_query_needs_weights: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_IDLE && q_pop && q_item.kind == KIND_QUERY) |-> wgt.ready)
		else $error("query started while weight table rebuilds");

	a_octave_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_READ || st_q == B_ACC) |-> (o_q < n_q))
		else $error("octave index beyond octave count");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == B_DONE))
		else $error("result raised outside the done state");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_DIV) |-> (rem_q < wsum_q))
		else $error("normalizing divide remainder out of range");

endmodule
`default_nettype wire

[rtl/octave_value_noise_2d.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// octave_value_noise_2d
// Multi-octave bilinear value noise over a square seed map, APB configured.
// -----------------------------------------------------------------------------
// A request word either writes one Q0.16 seed sample into the SIDE x SIDE map
// (req_type 0) or asks for the noise at pixel (coord_x, coord_y) (req_type 1);
// coordinates wrap modulo SIDE. Each query returns one Q0.16 noise word, writes
// return nothing, and results leave in request order. Requests go into a four
// word queue, so the source can keep sending until the queue is full while a
// query is worked on and while a finished result waits in the output
// register. A seed write retires straight from the idle state. A query works
// per octave through four reads from the single seed memory port and a
// five-step multiply/round/weight chain, then a 16-step radix-2 normalizing
// divide. The octave weights live in a small table that a bit-serial divider
// rebuilds after reset and after every persistence_bias write; queries
// wait in the queue meanwhile. Seeds are not cleared at reset: read only
// what has been written. Registers: 0x0 octave_count (clamped to
// 1..MAX_OCTAVES), 0x4 persistence_bias (Q8.8, raised to at least 26).
// -----------------------------------------------------------------------------
module octave_value_noise_2d #(
	parameter int SIDE        = 256,
	parameter int MAX_OCTAVES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ovn_req_if.sink          req,
	ovn_rsp_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import ovn_pkg::*;

	localparam int IW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

	logic [3:0]    octave_count_q;
	logic [15:0]   bias_q;
	logic [15:0]   bias_eff;
	logic          cfg_wr;
	reg_idx_t      reg_sel;
	logic          bias_wr;
	item_t         q_item;
	logic          q_valid;
	logic          q_pop;
	wgt_t          wgt;
	logic [IW-1:0] wgt_idx;

	// register file: index is the word address
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign bias_wr = cfg_wr && (reg_sel == REG_PERSISTENCE_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= 4'd8;
			bias_q         <= 16'd512;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_OCTAVE_COUNT:     octave_count_q <= pwdata[3:0];
				REG_PERSISTENCE_BIAS: bias_q         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_OCTAVE_COUNT:     prdata = {28'd0, octave_count_q};
			REG_PERSISTENCE_BIAS: prdata = {16'd0, bias_q};
			default:              prdata = '0;
		endcase
	end

	// hold the divisor at its floor of about 0.1
	assign bias_eff = (bias_q < BIAS_MIN) ? BIAS_MIN : bias_q;

	// front: accept and tag request words, queue them
	ovn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// weight table, rebuilt whenever the bias changes
	ovn_weight #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_weight (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (bias_wr),
		.bias    (bias_eff),
		.rd_idx  (wgt_idx),
		.wgt     (wgt)
	);

	// back: seed map, octave sampling, normalization, result register
	ovn_back #(
		.SIDE        (SIDE),
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_item       (q_item),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.octave_count (octave_count_q),
		.wgt          (wgt),
		.wgt_idx      (wgt_idx),
		.rsp          (rsp)
	);

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the octave value noise block: seeds every map entry
// that a query can reach, then streams directed and random noise queries and
// seed rewrites under several octave and bias settings, predicting every
// noise word in-bench.
// -----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ovn_pkg::*;

	localparam int MAP_SIDE   = 256;
	localparam int MAX_OCT    = 8;
	localparam int MIN_BIAS   = 26;
	localparam int PHASE_RAND = 230;
	localparam int N_CORNER   = 19;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ovn_req_if req ();
	ovn_rsp_if rsp ();

	octave_value_noise_2d dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Queries stay in columns and rows 0..15 and 248..255; every cell corner
	// that such a query touches, at any octave, is one of these lines.
	int corner_lines [N_CORNER] = '{0, 2, 4, 6, 8, 10, 12, 14, 16, 32, 64, 128,
		192, 224, 240, 248, 250, 252, 254};

	// mirrored block state
	logic [15:0] seed_mirror [MAP_SIDE*MAP_SIDE];
	logic [3:0]  octaves_set;
	logic [15:0] bias_set;

	item_t       pending_words [$];
	logic [15:0] noise_expected [$];

	int errors;
	int queries_sent;
	int writes_sent;
	int settings_used;
	int idle_pct;
	int hold_cycles;
	logic req_fired;

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic mismatch_report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Blend the four wrapped corner seeds of one pitch cell, rounded to nearest.
	function automatic longint unsigned cell_blend(input int x, input int y, input int p);
		int x1, y1, x2, y2;
		longint unsigned dx, dy, pp, top, bot, num, den;
		x1 = (x / p) * p;
		y1 = (y / p) * p;
		x2 = (x1 + p) % MAP_SIDE;
		y2 = (y1 + p) % MAP_SIDE;
		dx = x - x1;
		dy = y - y1;
		pp = p;
		top = (pp - dx) * seed_mirror[y1*MAP_SIDE + x1] + dx * seed_mirror[y1*MAP_SIDE + x2];
		bot = (pp - dx) * seed_mirror[y2*MAP_SIDE + x1] + dx * seed_mirror[y2*MAP_SIDE + x2];
		num = (pp - dy) * top + dy * bot;
		den = pp * pp;
		return (num + den / 2) / den;
	endfunction

	// Weighted octave sum, normalized by the summed weight.
	function automatic logic [15:0] noise_at(input logic [7:0] x, input logic [7:0] y);
		int n, o, p;
		longint unsigned b, w, wsum, acc;
		n = octaves_set;
		if (n < 1) n = 1;
		if (n > MAX_OCT) n = MAX_OCT;
		b = (bias_set < MIN_BIAS) ? MIN_BIAS : bias_set;
		w = 64'd1 << 24;
		wsum = 0;
		acc = 0;
		for (o = 0; o < n; o++) begin
			p = MAP_SIDE >> o;
			if (p == 0) p = 1;
			wsum += w;
			acc += w * cell_blend(x, y, p);
			w = (w * 256) / b;
		end
		return 16'((acc + wsum / 2) / wsum);
	endfunction

	// Query coordinate near either map edge, with the edges themselves favored.
	function automatic int query_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 255;
		if (r == 1)
			return 0;
		r = $urandom_range(0, 23);
		return (r < 16) ? r : r + 232;
	endfunction

	task automatic push_word(input kind_t k, input int x, input int y, input int s);
		item_t it;
		it.kind = k;
		it.x = 8'(x);
		it.y = 8'(y);
		it.seed = 16'(s);
		pending_words.push_back(it);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait until the block has drained, then let any trailing seed write retire.
	task automatic drain_block();
		while (pending_words.size() != 0 || noise_expected.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic load_setting(input int cnt, input int bias);
		drain_block();
		apb_write(REG_OCTAVE_COUNT, 32'(cnt));
		apb_write(REG_PERSISTENCE_BIAS, 32'(bias));
		settings_used++;
	endtask

	// Random mix: mostly queries, some seed rewrites on corner lines; query
	// coordinates lean on map edges and cell corners now and then.
	task automatic random_words(input int count);
		int i, x, y, s, r;
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 9);
			s = (r == 0) ? 16'hffff : (r == 1) ? 0 : $urandom_range(0, 65535);
			if ($urandom_range(0, 99) < 70) begin
				x = query_coord();
				y = query_coord();
				if ($urandom_range(0, 7) == 0)
					x = x & ~((1 << $urandom_range(0, 3)) - 1);
				push_word(KIND_QUERY, x, y, $urandom_range(0, 65535));
			end else begin
				x = corner_lines[$urandom_range(0, N_CORNER - 1)];
				y = corner_lines[$urandom_range(0, N_CORNER - 1)];
				push_word(KIND_WRITE, x, y, s);
			end
		end
	endtask

	// Stimulus and phase sequencing
	initial begin
		int i;
		errors = 0;
		queries_sent = 0;
		writes_sent = 0;
		settings_used = 0;
		idle_pct = 12;
		hold_cycles = 0;
		octaves_set = 4'd8;
		bias_set = 16'd512;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every seed a query can reach gets written first
		for (i = 0; i < N_CORNER*N_CORNER; i++)
			push_word(KIND_WRITE, corner_lines[i % N_CORNER], corner_lines[i / N_CORNER],
				$urandom_range(0, 65535));

		// directed: corners, seed extremes, wrap at both edges, reset setting
		push_word(KIND_QUERY, 0, 0, 0);
		push_word(KIND_QUERY, 255, 255, 16'hffff);
		push_word(KIND_WRITE, 254, 254, 16'hffff);
		push_word(KIND_WRITE, 0, 0, 0);
		push_word(KIND_WRITE, 254, 0, 16'hffff);
		push_word(KIND_WRITE, 0, 254, 16'h8000);
		push_word(KIND_QUERY, 255, 255, 0);
		push_word(KIND_QUERY, 255, 0, 0);
		push_word(KIND_QUERY, 0, 255, 0);
		push_word(KIND_QUERY, 0, 0, 0);
		push_word(KIND_QUERY, 8, 8, 0);
		push_word(KIND_QUERY, 15, 249, 0);
		random_words(PHASE_RAND);

		// zero octaves, minimum bias; no idling on either side here
		load_setting(0, 0);
		idle_pct = 0;
		push_word(KIND_QUERY, 255, 1, 0);
		push_word(KIND_QUERY, 3, 254, 0);
		random_words(PHASE_RAND);
		drain_block();
		idle_pct = 12;

		// too many octaves, bias just under the floor; sink backs off long
		load_setting(15, 25);
		hold_cycles = 2000;
		push_word(KIND_QUERY, 250, 13, 0);
		random_words(PHASE_RAND);

		load_setting(1, 26);
		random_words(PHASE_RAND);

		load_setting(8, 65535);
		random_words(PHASE_RAND);

		load_setting($urandom_range(2, 7), $urandom_range(27, 4000));
		random_words(PHASE_RAND);

		drain_block();
		$display("covered %0d queries and %0d seed writes over %0d register settings",
			queries_sent, writes_sent, settings_used + 1);
		if (errors == 0)
			$display("PASS octave_value_noise_2d");
		else
			$display("FAIL octave_value_noise_2d");
		$finish;
	end

	// Driver: advance to the next word once the current one is taken, or idle.
	initial begin
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.coord_x = '0;
		req.coord_y = '0;
		req.seed_value = '0;
		rsp.ready = 1'b0;
	end

	always @(negedge clk) begin
		item_t it;
		if (arst_n && (!req.valid || req_fired)) begin
			if (pending_words.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
				req.valid <= 1'b0;
			end else begin
				it = pending_words.pop_front();
				req.valid <= 1'b1;
				req.req_type <= it.kind;
				req.coord_x <= it.x;
				req.coord_y <= it.y;
				req.seed_value <= it.seed;
			end
		end
	end

	// Response sink: random stalls, plus a long counted hold-off when asked.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= arst_n && ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Monitor: predict on accepted requests, check accepted noise words.
	always @(posedge clk) begin
		logic [15:0] want;
		req_fired <= req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			if (req.req_type == KIND_WRITE) begin
				seed_mirror[{req.coord_y, req.coord_x}] = req.seed_value;
				writes_sent++;
			end else begin
				noise_expected.push_back(noise_at(req.coord_x, req.coord_y));
				queries_sent++;
			end
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (noise_expected.size() == 0) begin
				mismatch_report($sformatf("unexpected noise word %h", rsp.noise_value));
			end else begin
				want = noise_expected.pop_front();
				if (rsp.noise_value !== want)
					mismatch_report($sformatf("noise_value %h, want %h",
						rsp.noise_value, want));
			end
		end
	end

	// register mirror follows the APB access phase
	always @(posedge clk) begin
		if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_OCTAVE_COUNT)
				octaves_set <= pwdata[3:0];
			else
				bias_set <= pwdata[15:0];
		end
	end

	initial begin
		#50ms;
		$display("FAIL octave_value_noise_2d");
		$finish;
	end

endmodule
